// ===== design/sorted_table_bracket_search_assert.svh =====
// Assertion macros for the sorted table bracket search block.
// Needs signals clk and rst in the scope of each use.
`ifndef SORTED_TABLE_BRACKET_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BRACKET_SEARCH_ASSERT_SVH

// same-cycle implication
`define STBS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/stbs_pkg.sv =====
// Shared types and constants for the sorted table bracket search block.
// No dependencies; used by stbs_seq, stbs_dp and the top level.
package stbs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned CFG_W   = 11;   // configuration register width
  localparam int unsigned IDX_W   = 10;   // index fields of the words
  localparam int unsigned VAL_W   = 64;   // Q32.32 value
  localparam int unsigned SW      = 14;   // signed search index width
  localparam int unsigned STEP_W  = 5;    // microcode step counter
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_LOCATE = 2'd1;
  localparam logic [1:0] CMD_HUNT   = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] REG_TABLE_LENGTH   = 2'd0;
  localparam logic [1:0] REG_WINDOW_POINTS  = 2'd1;
  localparam logic [1:0] REG_CORR_DISTANCE  = 2'd2;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] window_start;
    logic [IDX_W-1:0] bracket_index;
    logic             correlated;
    logic             status;
  } rsp_t;

  // table read address source
  typedef enum logic [2:0] {
    A_ZERO, A_NM1, A_LAST, A_UP, A_DN, A_MID
  } addr_sel_t;

  // datapath micro-operation
  typedef enum logic [4:0] {
    U_NOP, U_LOAD_T0, U_ASC_INIT, U_UP_STEP, U_UP_ADV, U_HI_NM1, U_HI_LO,
    U_DN_STEP, U_DN_ADV, U_LO_ZERO, U_LOC_INIT, U_MID, U_BIS_UPD,
    U_FIN_QUERY, U_FIN_WRITE, U_FIN_ZERO, U_FIN_ERR
  } uop_t;

  // jump condition
  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_CMD_WR, C_CMD_NONE, C_SIZE_ERR, C_LOCATE,
    C_SIDE, C_OFF_SIDE, C_UP_CLAMP, C_DN_CLAMP, C_NARROW
  } cond_t;

  typedef struct packed {
    addr_sel_t         addr;
    uop_t              op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              done;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic cmd_wr;
    logic cmd_none;
    logic size_err;
    logic locate;
    logic side;
    logic up_clamp;
    logic dn_clamp;
    logic narrow;
  } flags_t;

  typedef struct packed {
    logic busy;
    logic adv;
    logic fin;
  } seq_stat_t;

endpackage

// ===== design/stbs_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
// Depends on stbs_pkg.
module stbs_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               hold,
  input  stbs_pkg::flags_t   flags,
  output stbs_pkg::ctrl_t    ctrl,
  output stbs_pkg::seq_stat_t stat
);
  import stbs_pkg::*;

  localparam logic [STEP_W-1:0] S_UP        = STEP_W'(6);
  localparam logic [STEP_W-1:0] S_UP_CLAMP  = STEP_W'(9);
  localparam logic [STEP_W-1:0] S_DN_INIT   = STEP_W'(10);
  localparam logic [STEP_W-1:0] S_DN        = STEP_W'(11);
  localparam logic [STEP_W-1:0] S_DN_CLAMP  = STEP_W'(14);
  localparam logic [STEP_W-1:0] S_LOC_INIT  = STEP_W'(15);
  localparam logic [STEP_W-1:0] S_BISECT    = STEP_W'(16);
  localparam logic [STEP_W-1:0] S_FIN_QUERY = STEP_W'(18);
  localparam logic [STEP_W-1:0] S_WRITE     = STEP_W'(19);
  localparam logic [STEP_W-1:0] S_FIN_ZERO  = STEP_W'(20);
  localparam logic [STEP_W-1:0] S_FIN_ERR   = STEP_W'(21);

  // control store; a read issued in one step is compared in the next
  function automatic ctrl_t rom(input logic [STEP_W-1:0] s);
    ctrl_t w;
    w.addr   = A_ZERO;
    w.op     = U_NOP;
    w.cond   = C_NEVER;
    w.target = '0;
    w.done   = 1'b0;
    case (s)
      STEP_W'(0): begin
        w.cond = C_CMD_WR;   w.target = S_WRITE;
      end
      STEP_W'(1): begin
        w.cond = C_CMD_NONE; w.target = S_FIN_ZERO;
      end
      STEP_W'(2): begin
        w.addr = A_ZERO; w.cond = C_SIZE_ERR; w.target = S_FIN_ERR;
      end
      STEP_W'(3): begin
        w.addr = A_NM1; w.op = U_LOAD_T0;
      end
      STEP_W'(4): begin
        w.addr = A_LAST; w.op = U_ASC_INIT; w.cond = C_LOCATE; w.target = S_LOC_INIT;
      end
      STEP_W'(5): begin
        w.cond = C_OFF_SIDE; w.target = S_DN_INIT;
      end
      S_UP: begin
        w.addr = A_UP; w.op = U_UP_STEP; w.cond = C_UP_CLAMP; w.target = S_UP_CLAMP;
      end
      STEP_W'(7): begin
        w.cond = C_OFF_SIDE; w.target = S_BISECT;
      end
      STEP_W'(8): begin
        w.op = U_UP_ADV; w.cond = C_ALWAYS; w.target = S_UP;
      end
      S_UP_CLAMP: begin
        w.op = U_HI_NM1; w.cond = C_ALWAYS; w.target = S_BISECT;
      end
      S_DN_INIT: begin
        w.op = U_HI_LO;
      end
      S_DN: begin
        w.addr = A_DN; w.op = U_DN_STEP; w.cond = C_DN_CLAMP; w.target = S_DN_CLAMP;
      end
      STEP_W'(12): begin
        w.cond = C_SIDE; w.target = S_BISECT;
      end
      STEP_W'(13): begin
        w.op = U_DN_ADV; w.cond = C_ALWAYS; w.target = S_DN;
      end
      S_DN_CLAMP: begin
        w.op = U_LO_ZERO; w.cond = C_ALWAYS; w.target = S_BISECT;
      end
      S_LOC_INIT: begin
        w.op = U_LOC_INIT;
      end
      S_BISECT: begin
        w.addr = A_MID; w.op = U_MID; w.cond = C_NARROW; w.target = S_FIN_QUERY;
      end
      STEP_W'(17): begin
        w.op = U_BIS_UPD; w.cond = C_ALWAYS; w.target = S_BISECT;
      end
      S_FIN_QUERY: begin
        w.op = U_FIN_QUERY; w.done = 1'b1;
      end
      S_WRITE: begin
        w.op = U_FIN_WRITE; w.done = 1'b1;
      end
      S_FIN_ERR: begin
        w.op = U_FIN_ERR; w.done = 1'b1;
      end
      default: begin
        w.op = U_FIN_ZERO; w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] step;
  logic              busy;
  logic              taken;
  logic              adv;

  assign ctrl = rom(step);
  assign adv  = busy && !(ctrl.done && hold);

  always_comb begin
    case (ctrl.cond)
      C_ALWAYS:   taken = 1'b1;
      C_CMD_WR:   taken = flags.cmd_wr;
      C_CMD_NONE: taken = flags.cmd_none;
      C_SIZE_ERR: taken = flags.size_err;
      C_LOCATE:   taken = flags.locate;
      C_SIDE:     taken = flags.side;
      C_OFF_SIDE: taken = !flags.side;
      C_UP_CLAMP: taken = flags.up_clamp;
      C_DN_CLAMP: taken = flags.dn_clamp;
      C_NARROW:   taken = flags.narrow;
      default:    taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (adv) begin
      if (ctrl.done) begin
        busy <= 1'b0;
      end else if (taken) begin
        step <= ctrl.target;
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

  assign stat.busy = busy;
  assign stat.adv  = adv;
  assign stat.fin  = adv && ctrl.done;

endmodule

// ===== design/stbs_dp.sv =====
// Search datapath: table memory, bracket registers and result arithmetic.
// Depends on stbs_pkg; driven by control words from stbs_seq.
module stbs_dp #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  stbs_pkg::req_t               req,
  input  logic                         adv,
  input  stbs_pkg::ctrl_t              ctrl,
  input  logic [stbs_pkg::CFG_W-1:0]   table_length,
  input  logic [stbs_pkg::CFG_W-1:0]   window_points,
  input  logic [stbs_pkg::CFG_W-1:0]   correlation_distance,
  output stbs_pkg::flags_t             flags,
  output stbs_pkg::rsp_t               result
);
  import stbs_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [VAL_W-1:0]    mem [TABLE_DEPTH];
  logic [VAL_W-1:0]    rdata;

  logic [1:0]          cmd;
  logic [IDX_W-1:0]    entry_index;
  logic signed [VAL_W-1:0] x;
  logic signed [VAL_W-1:0] t0;
  logic                asc;
  logic signed [SW-1:0] lo, hi, inc, mid;
  logic [CFG_W-1:0]    last;

  logic signed [SW-1:0] n_s, m_s, d_s, nm1, last_s;
  logic signed [SW-1:0] up_idx, dn_idx, mid_idx, rd_idx;
  logic [AW-1:0]       raddr_w, waddr_w;
  logic                wr_ok;
  logic                ge;

  logic signed [SW-1:0] diff, adiff, half, ws0, nmm, ws1, ws;

  assign n_s    = $signed({{(SW-CFG_W){1'b0}}, table_length});
  assign m_s    = $signed({{(SW-CFG_W){1'b0}}, window_points});
  assign d_s    = $signed({{(SW-CFG_W){1'b0}}, correlation_distance});
  assign last_s = $signed({{(SW-CFG_W){1'b0}}, last});
  assign nm1    = n_s - SW'(1);
  assign up_idx = lo + inc;
  assign dn_idx = lo - inc;
  assign mid_idx = (lo + hi) >>> 1;

  always_comb begin
    case (ctrl.addr)
      A_NM1:   rd_idx = nm1;
      A_LAST:  rd_idx = last_s;
      A_UP:    rd_idx = up_idx;
      A_DN:    rd_idx = dn_idx;
      A_MID:   rd_idx = mid_idx;
      default: rd_idx = '0;
    endcase
  end

  assign raddr_w = AW'($unsigned(rd_idx));
  assign waddr_w = AW'(entry_index);
  assign wr_ok   = 32'(entry_index) < 32'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (adv && (ctrl.op == U_FIN_WRITE) && wr_ok) begin
      mem[waddr_w] <= x;
    end
    rdata <= mem[raddr_w];
  end

  // query at or above the entry just read, signed order
  assign ge = x >= $signed(rdata);

  assign flags.cmd_wr   = (cmd == CMD_WRITE);
  assign flags.cmd_none = (cmd == CMD_NONE);
  assign flags.size_err = (table_length < CFG_W'(2)) || (window_points < CFG_W'(2)) ||
                          (window_points > table_length) ||
                          (32'(table_length) > 32'(TABLE_DEPTH));
  assign flags.locate   = (cmd == CMD_LOCATE) || (last_s > nm1);
  assign flags.side     = (ge == asc);
  assign flags.up_clamp = up_idx >= nm1;
  assign flags.dn_clamp = dn_idx <= SW'(0);
  assign flags.narrow   = (hi - lo) <= SW'(1);

  // result arithmetic
  assign diff  = lo - last_s;
  assign adiff = (diff < 0) ? -diff : diff;
  assign half  = (m_s - SW'(2)) >>> 1;
  assign ws0   = lo - half;
  assign nmm   = n_s - m_s;
  assign ws1   = (ws0 > nmm) ? nmm : ws0;
  assign ws    = (ws1 < 0) ? SW'(0) : ws1;

  always_comb begin
    result = '0;
    case (ctrl.op)
      U_FIN_QUERY: begin
        result.window_start  = ws[IDX_W-1:0];
        result.bracket_index = lo[IDX_W-1:0];
        result.correlated    = adiff <= d_s;
      end
      U_FIN_ERR: result.status = 1'b1;
      default:   result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last <= '0;
    end else if (load) begin
      cmd         <= req.cmd;
      entry_index <= req.entry_index;
      x           <= req.value;
    end else if (adv) begin
      case (ctrl.op)
        U_LOAD_T0:  t0 <= $signed(rdata);
        U_ASC_INIT: begin
          asc <= $signed(rdata) >= t0;
          lo  <= last_s;
          inc <= SW'(1);
        end
        U_UP_STEP:  hi <= up_idx;
        U_UP_ADV: begin
          lo  <= hi;
          inc <= inc <<< 1;
        end
        U_HI_NM1:   hi <= nm1;
        U_HI_LO:    hi <= lo;
        U_DN_STEP:  lo <= dn_idx;
        U_DN_ADV: begin
          hi  <= lo;
          inc <= inc <<< 1;
        end
        U_LO_ZERO:  lo <= '0;
        U_LOC_INIT: begin
          lo <= '0;
          hi <= nm1;
        end
        U_MID:      mid <= mid_idx;
        U_BIS_UPD: begin
          if (ge == asc) begin
            lo <= mid;
          end else begin
            hi <= mid;
          end
        end
        U_FIN_QUERY: last <= lo[CFG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/sorted_table_bracket_search.sv =====
// Top level of the sorted table bracket search: handshake, APB registers, result word.
// Depends on stbs_pkg, stbs_seq, stbs_dp and sorted_table_bracket_search_assert.svh.
//
// One word is worked on at a time; req_ready is high whenever no word is in flight,
// also while a result still waits on rsp. Each word runs the microcode program, and
// each probe waits on the registered table read. A write, an unused command and a
// size error end without a search; a locate bisects over the whole table. A hunt
// doubles its step from the last bracket, upward or downward, until a probe brackets
// the query or the table end is reached, then bisects over the bracket found and
// finishes. The last step of a word waits while the previous result is still
// unread. The table holds TABLE_DEPTH entries, undefined until written; the
// direction (ascending or descending) is taken from entries 0 and n-1 on every
// query.
`include "sorted_table_bracket_search_assert.svh"

module sorted_table_bracket_search #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  stbs_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output stbs_pkg::rsp_t                rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stbs_pkg::PADDR_W-1:0]  paddr,
  input  logic [stbs_pkg::PDATA_W-1:0]  pwdata,
  output logic [stbs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import stbs_pkg::*;

  logic [CFG_W-1:0] table_length;
  logic [CFG_W-1:0] window_points;
  logic [CFG_W-1:0] correlation_distance;

  ctrl_t     ctrl;
  flags_t    flags;
  seq_stat_t stat;
  rsp_t      result;
  logic      load;
  logic      hold;
  logic      cfg_wr;

  assign req_ready = !stat.busy;
  assign load      = req_valid && req_ready;
  assign hold      = rsp_valid && !rsp_ready;

  stbs_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (load),
    .hold  (hold),
    .flags (flags),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .load                 (load),
    .req                  (req),
    .adv                  (stat.adv),
    .ctrl                 (ctrl),
    .table_length         (table_length),
    .window_points        (window_points),
    .correlation_distance (correlation_distance),
    .flags                (flags),
    .result               (result)
  );

  // result word; the sequencer holds its last step while this is full and not taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stat.fin) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.fin) begin
      rsp <= result;
    end
  end

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length         <= CFG_W'(2);
      window_points        <= CFG_W'(2);
      correlation_distance <= CFG_W'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TABLE_LENGTH:  table_length         <= pwdata[CFG_W-1:0];
        REG_WINDOW_POINTS: window_points        <= pwdata[CFG_W-1:0];
        REG_CORR_DISTANCE: correlation_distance <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TABLE_LENGTH:  prdata = PDATA_W'(table_length);
      REG_WINDOW_POINTS: prdata = PDATA_W'(window_points);
      REG_CORR_DISTANCE: prdata = PDATA_W'(correlation_distance);
      default:           prdata = '0;
    endcase
  end

  `STBS_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, stat.busy, "accept did not start")
  `STBS_ASSERT_NEXT(a_fin_delivers, stat.fin, rsp_valid, "finished word not on rsp")
  `STBS_ASSERT_IMPL(a_err_word, rsp_valid && rsp.status,
                    rsp.window_start == '0 && rsp.bracket_index == '0 && !rsp.correlated,
                    "size error word carries index data")

endmodule
